// ===== rtl/core/pfb_pkg.sv =====
// Shared constants, types and helpers for the paged LCD frame buffer.
// No dependencies; imported by the top level, pfb_ctrl and pfb_emit.
package pfb_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = PAGES * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // op codes
  localparam logic [2:0] OP_SET_PIXEL  = 3'd0;
  localparam logic [2:0] OP_GET_PIXEL  = 3'd1;
  localparam logic [2:0] OP_WRITE_PAGE = 3'd2;
  localparam logic [2:0] OP_READ_PAGE  = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // lcd command prefixes (upper nibble)
  localparam logic [3:0] CMD_PAGE_HI  = 4'hB;
  localparam logic [3:0] CMD_COLL_HI  = 4'h0;
  localparam logic [3:0] CMD_COLH_HI  = 4'h1;

  localparam logic OUT_READ = 1'b0;
  localparam logic OUT_LCD  = 1'b1;
  localparam logic A0_CMD   = 1'b0;
  localparam logic A0_DATA  = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic       is_read;
    logic [3:0] page;
    logic [7:0] col;
    logic [7:0] value;
  } emit_desc_t;

  function automatic logic in_range(logic signed [8:0] col, logic signed [7:0] row);
    logic col_ok;
    logic row_ok;
    col_ok = !col[8] && ({1'b0, col[7:0]} < 9'(COLUMNS));
    row_ok = !row[7] && ({1'b0, row[6:0]} < 8'(ROWS));
    return col_ok && row_ok;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(logic [3:0] page, logic [7:0] col);
    return ADDR_W'(int'(page) * COLUMNS + int'(col));
  endfunction

endpackage

// ===== rtl/core/paged_lcd_frame_buffer_unit.sv =====
// Top level of the paged LCD frame buffer: store RAM, sequencer and emitter.
// Depends on pfb_pkg, pfb_ram, pfb_ctrl and pfb_emit.
//
//   port group   | direction | handshake               | payload
//   -------------+-----------+-------------------------+----------------------------------
//   in           | in        | in_valid_i / in_ready_o | op, col, row, color, page_byte
//   out          | out       | out_valid_o/out_ready_i | out_kind, lcd_a0, lcd_byte,
//                |           |                         | read_value, last
//   cfg          | in        | cfg_we_i                | cfg_wdata_i (instant_send)
//
// An item goes through the sequencer as a store read, then a modify and write
// back; a write with instant send then plays out four lcd bytes. The sequencer
// takes the next item while the emitter still plays out the last result.
// After reset and after a clear item the 1024 entries of the store (PAGES *
// COLUMNS) are swept to zero, one entry a cycle; no item is taken meanwhile.
// A stalled output holds the sequencer only once a second result is ready.
module paged_lcd_frame_buffer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  logic signed [8:0] col_i,
  input  logic signed [7:0] row_i,
  input  logic              color_i,
  input  logic [7:0]        page_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic              lcd_a0_o,
  output logic [7:0]        lcd_byte_o,
  output logic [7:0]        read_value_o,
  output logic              last_o
);
  import pfb_pkg::*;

  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  ram_wr_t           ram_wr;
  logic [7:0]        ram_rdata;
  logic              emit_valid;
  emit_desc_t        emit_desc;
  logic              emit_ready;

  pfb_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (8),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .color_i      (color_i),
    .page_byte_i  (page_byte_i),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_wr_o     (ram_wr),
    .ram_rdata_i  (ram_rdata),
    .emit_valid_o (emit_valid),
    .emit_desc_o  (emit_desc),
    .emit_ready_i (emit_ready)
  );

  pfb_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit_valid),
    .desc_i       (emit_desc),
    .ready_o      (emit_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .lcd_a0_o     (lcd_a0_o),
    .lcd_byte_o   (lcd_byte_o),
    .read_value_o (read_value_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/core/pfb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pfb_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pfb_ctrl.sv =====
// Operation sequencer: decodes items, does read-modify-write on the store,
// sweeps the store clear and hands results to the emitter. Uses pfb_pkg.
module pfb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            op_i,
  input  logic signed [8:0]     col_i,
  input  logic signed [7:0]     row_i,
  input  logic                  color_i,
  input  logic [7:0]            page_byte_i,
  output logic                  ram_re_o,
  output logic [pfb_pkg::ADDR_W-1:0] ram_raddr_o,
  output pfb_pkg::ram_wr_t      ram_wr_o,
  input  logic [7:0]            ram_rdata_i,
  output logic                  emit_valid_o,
  output pfb_pkg::emit_desc_t   emit_desc_o,
  input  logic                  emit_ready_i
);
  import pfb_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_MODIFY = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic              instant_send_q;

  logic [2:0]        op_q;
  logic              ok_q;
  logic [3:0]        page_q;
  logic [7:0]        col_q;
  logic [2:0]        bit_q;
  logic              color_q;
  logic [7:0]        pbyte_q;

  logic              in_ok;
  logic [3:0]        in_page;
  logic [7:0]        in_col;
  logic              accept;

  logic              is_read_op;
  logic              is_write_op;
  logic              do_write;
  logic              need_emit;
  logic              go;
  logic [7:0]        mask;
  logic [7:0]        new_byte;
  logic [7:0]        read_val;

  assign in_ok   = in_range(col_i, row_i);
  assign in_page = in_ok ? row_i[6:3] : 4'd0;
  assign in_col  = in_ok ? col_i[7:0] : 8'd0;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign ram_re_o    = accept;
  assign ram_raddr_o = addr_of(in_page, in_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instant_send_q <= 1'b0;
    end else if (cfg_we_i) begin
      instant_send_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      ok_q    <= in_ok;
      page_q  <= in_page;
      col_q   <= in_col;
      bit_q   <= in_ok ? row_i[2:0] : 3'd0;
      color_q <= color_i;
      pbyte_q <= page_byte_i;
    end
  end

  assign is_read_op  = (op_q == OP_GET_PIXEL) || (op_q == OP_READ_PAGE);
  assign is_write_op = (op_q == OP_SET_PIXEL) || (op_q == OP_WRITE_PAGE);
  assign do_write    = is_write_op && ok_q;
  assign need_emit   = is_read_op || (do_write && instant_send_q);
  assign go          = !need_emit || emit_ready_i;

  assign mask = 8'(1) << bit_q;

  always_comb begin
    new_byte = pbyte_q;
    if (op_q == OP_SET_PIXEL) begin
      new_byte = color_q ? (ram_rdata_i | mask) : (ram_rdata_i & ~mask);
    end
    read_val = 8'd0;
    if (ok_q) begin
      read_val = (op_q == OP_GET_PIXEL) ? {7'd0, ram_rdata_i[bit_q]} : ram_rdata_i;
    end
  end

  always_comb begin
    emit_desc_o.is_read = is_read_op;
    emit_desc_o.page    = page_q;
    emit_desc_o.col     = col_q;
    emit_desc_o.value   = is_read_op ? read_val : new_byte;
  end

  assign emit_valid_o = (state_q == ST_MODIFY) && need_emit;

  always_comb begin
    state_d       = state_q;
    sweep_d       = sweep_q;
    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = addr_of(page_q, col_q);
    ram_wr_o.data = new_byte;
    unique case (state_q)
      ST_CLEAR: begin
        ram_wr_o.we   = 1'b1;
        ram_wr_o.addr = sweep_q;
        ram_wr_o.data = 8'd0;
        sweep_d       = sweep_q + ADDR_W'(1);
        if (sweep_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_CLEAR) begin
            state_d = ST_CLEAR;
            sweep_d = '0;
          end else if (op_i <= OP_READ_PAGE) begin
            state_d = ST_MODIFY;
          end
        end
      end
      ST_MODIFY: begin
        // when a result is to be emitted, wait here until the emitter can take it
        if (go) begin
          ram_wr_o.we = do_write;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

endmodule

// ===== rtl/core/pfb_emit.sv =====
// Result emitter: holds one result descriptor and plays it out as one read
// answer or four lcd bytes. Uses pfb_pkg.
module pfb_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  pfb_pkg::emit_desc_t desc_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_kind_o,
  output logic                lcd_a0_o,
  output logic [7:0]          lcd_byte_o,
  output logic [7:0]          read_value_o,
  output logic                last_o
);
  import pfb_pkg::*;

  emit_desc_t desc_q;
  logic       busy_q, busy_d;
  logic [1:0] beat_q, beat_d;
  logic       is_last;
  logic       done;

  assign is_last = desc_q.is_read || (beat_q == 2'd3);
  assign done    = busy_q && out_ready_i && is_last;
  assign ready_o = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    if (busy_q && out_ready_i) begin
      beat_d = beat_q + 2'd1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (load_i && ready_o) begin
      busy_d = 1'b1;
      beat_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      desc_q <= desc_i;
    end
  end

  assign out_valid_o = busy_q;
  assign last_o      = is_last;

  always_comb begin
    out_kind_o   = OUT_LCD;
    lcd_a0_o     = A0_CMD;
    lcd_byte_o   = 8'd0;
    read_value_o = 8'd0;
    if (desc_q.is_read) begin
      out_kind_o   = OUT_READ;
      read_value_o = desc_q.value;
    end else begin
      case (beat_q)
        2'd0: lcd_byte_o = {CMD_PAGE_HI, desc_q.page};
        2'd1: lcd_byte_o = {CMD_COLL_HI, desc_q.col[3:0]};
        2'd2: lcd_byte_o = {CMD_COLH_HI, desc_q.col[7:4]};
        default: begin
          lcd_a0_o   = A0_DATA;
          lcd_byte_o = desc_q.value;
        end
      endcase
    end
  end

endmodule
